@@ hdl/euler_to_quaternion_pose_macros.svh @@
// assertion helpers
`ifndef EULER_TO_QUATERNION_POSE_MACROS_SVH
`define EULER_TO_QUATERNION_POSE_MACROS_SVH
`ifndef SYNTHESIS
`define E2Q_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define E2Q_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define E2Q_ASSERT(label, clk, rst, prop, msg)
`define E2Q_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

@@ hdl/e2q_pkg.sv @@
package e2q_pkg;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int QUAT_FRAC_BITS_DEF = 15;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int POS_BITS = 24;
  localparam int WORK_FRAC = 30;
  // cordic datapath: Q2.30 plus guard bit
  localparam int CW = 34;
  localparam int ZW = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [POS_BITS-1:0] BASE_X_RST = 24'sd133120;
  localparam logic signed [POS_BITS-1:0] BASE_Z_RST = 24'sd153600;
  localparam int ANGLE_DIVISOR = 2;

  typedef enum logic [1:0] {
    REG_ORIGIN_X = 2'd0,
    REG_ORIGIN_Y = 2'd1,
    REG_ORIGIN_Z = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0] x;
    logic signed [POS_BITS-1:0] y;
    logic signed [POS_BITS-1:0] z;
    logic signed [POS_BITS-1:0] ext;
  } pos_t;

  function automatic logic signed [ZW-1:0] atan_turn(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 34'sd536870912;  1: r = 34'sd316933406;  2: r = 34'sd167458907;
      3: r = 34'sd85004756;   4: r = 34'sd42667331;   5: r = 34'sd21354465;
      6: r = 34'sd10679838;   7: r = 34'sd5340245;    8: r = 34'sd2670163;
      9: r = 34'sd1335087;    10: r = 34'sd667544;    11: r = 34'sd333772;
      12: r = 34'sd166886;    13: r = 34'sd83443;     14: r = 34'sd41722;
      15: r = 34'sd20861;     16: r = 34'sd10430;     17: r = 34'sd5215;
      18: r = 34'sd2608;      19: r = 34'sd1304;      20: r = 34'sd652;
      21: r = 34'sd326;       22: r = 34'sd163;       23: r = 34'sd81;
      24: r = 34'sd41;        25: r = 34'sd20;        26: r = 34'sd10;
      27: r = 34'sd5;         28: r = 34'sd3;         29: r = 34'sd1;
      30: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

@@ hdl/euler_to_quaternion_pose.sv @@
// euler-angle pose to quaternion converter
// channels: start with roll/pitch/yaw angles, position and external axis;
//   busy is always low, so a request may be taken every cycle
// results appear on the output ports for one cycle with done high;
//   the receiver cannot stall, so nothing is held back
// pipeline: 16-stage cordic by default, two multiply stages, one add stage,
//   one round stage and one output register
// throughput: one request per cycle, set by the fully pipelined cordic
// configuration: cfg_we, cfg_index, cfg_data write the base-frame origin
//   registers x, y, z; writes beyond index 2 are dropped
// reset: rst clears the pipeline valid bits and loads the origin with
//   520 mm, 0, 600 mm; anything in flight is discarded
// position and external axis ride a delay line beside the quaternion path;
//   the origin is added at the output stage with saturation
`include "euler_to_quaternion_pose_macros.svh"
module euler_to_quaternion_pose #(
  parameter int ANGLE_BITS = e2q_pkg::ANGLE_BITS_DEF,
  parameter int QUAT_FRAC_BITS = e2q_pkg::QUAT_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic signed [e2q_pkg::POS_BITS-1:0] cfg_data,
  input  logic signed [ANGLE_BITS-1:0] roll_angle,
  input  logic signed [ANGLE_BITS-1:0] pitch_angle,
  input  logic signed [ANGLE_BITS-1:0] yaw_angle,
  input  logic signed [e2q_pkg::POS_BITS-1:0] pos_x,
  input  logic signed [e2q_pkg::POS_BITS-1:0] pos_y,
  input  logic signed [e2q_pkg::POS_BITS-1:0] pos_z,
  input  logic signed [e2q_pkg::POS_BITS-1:0] ext_axis_in,
  output logic done,
  output logic signed [e2q_pkg::POS_BITS-1:0] world_x,
  output logic signed [e2q_pkg::POS_BITS-1:0] world_y,
  output logic signed [e2q_pkg::POS_BITS-1:0] world_z,
  output logic signed [QUAT_FRAC_BITS:0] quat_w,
  output logic signed [QUAT_FRAC_BITS:0] quat_x,
  output logic signed [QUAT_FRAC_BITS:0] quat_y,
  output logic signed [QUAT_FRAC_BITS:0] quat_z,
  output logic signed [e2q_pkg::POS_BITS-1:0] ext_axis_out
);
  localparam int PB = e2q_pkg::POS_BITS;
  localparam int CW = e2q_pkg::CW;
  localparam int LAT = CORDIC_STAGES + 4;

  logic signed [PB-1:0] origin_x, origin_y, origin_z;
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= e2q_pkg::BASE_X_RST;
      origin_y <= '0;
      origin_z <= e2q_pkg::BASE_Z_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        e2q_pkg::REG_ORIGIN_X: origin_x <= cfg_data;
        e2q_pkg::REG_ORIGIN_Y: origin_y <= cfg_data;
        e2q_pkg::REG_ORIGIN_Z: origin_z <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;
  logic accept;
  assign accept = start && !busy;

  logic signed [CW-1:0] c0, s0, c1, s1, c2, s2;
  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .angle(roll_angle), .cos_q30(c0), .sin_q30(s0));
  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .angle(pitch_angle), .cos_q30(c1), .sin_q30(s1));
  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
    .clk(clk), .angle(yaw_angle), .cos_q30(c2), .sin_q30(s2));

  logic signed [QUAT_FRAC_BITS:0] qw, qx, qy, qz;
  e2q_quat #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_quat (
    .clk(clk), .c0(c0), .s0(s0), .c1(c1), .s1(s1), .c2(c2), .s2(s2),
    .qw(qw), .qx(qx), .qy(qy), .qz(qz));

  // valid bits and position delay line alongside the angle path
  logic [LAT-1:0] vld;
  e2q_pkg::pos_t pos_d [LAT];
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[LAT-2:0], accept};
  end
  always_ff @(posedge clk) begin
    pos_d[0] <= '{x: pos_x, y: pos_y, z: pos_z, ext: ext_axis_in};
    for (int i = 1; i < LAT; i++) pos_d[i] <= pos_d[i-1];
  end

  function automatic logic signed [PB-1:0] add_sat(input logic signed [PB-1:0] a,
                                                   input logic signed [PB-1:0] b);
    logic signed [PB:0] s;
    s = {a[PB-1], a} + {b[PB-1], b};
    if (s[PB] != s[PB-1]) return s[PB] ? {1'b1, {(PB-1){1'b0}}} : {1'b0, {(PB-1){1'b1}}};
    return s[PB-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= vld[LAT-1];
  end
  always_ff @(posedge clk) begin
    world_x <= add_sat(pos_d[LAT-1].x, origin_x);
    world_y <= add_sat(pos_d[LAT-1].y, origin_y);
    world_z <= add_sat(pos_d[LAT-1].z, origin_z);
    ext_axis_out <= pos_d[LAT-1].ext;
    quat_w <= qw;
    quat_x <= qx;
    quat_y <= qy;
    quat_z <= qz;
  end

  `E2Q_ASSERT(a_done_lat, clk, rst, done |-> $past(vld[LAT-1]), "done without request")
  `E2Q_ASSERT(a_never_busy, clk, rst, !busy, "busy raised")
  `E2Q_ASSERT_RST(a_rst_clear, clk, rst |=> !done, "done after reset")
endmodule

@@ hdl/e2q_cordic.sv @@
module e2q_cordic #(
  parameter int ANGLE_BITS = e2q_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES_DEF
) (
  input  logic clk,
  input  logic signed [ANGLE_BITS-1:0] angle,
  output logic signed [e2q_pkg::CW-1:0] cos_q30,
  output logic signed [e2q_pkg::CW-1:0] sin_q30
);
  localparam int CW = e2q_pkg::CW;
  localparam int ZW = e2q_pkg::ZW;
  logic signed [CW-1:0] xs [CORDIC_STAGES+1];
  logic signed [CW-1:0] ys [CORDIC_STAGES+1];
  logic signed [ZW-1:0] zs [CORDIC_STAGES+1];
  logic signed [63:0] z_wide;

  // half angle in units of 2^-32 turn
  assign z_wide = (64'(signed'(angle)) <<< 31) >>> (ANGLE_BITS + e2q_pkg::ANGLE_DIVISOR - 2);
  assign xs[0] = e2q_pkg::CORDIC_GAIN_Q30;
  assign ys[0] = '0;
  assign zs[0] = ZW'(z_wide);

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!zs[i][ZW-1]) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - e2q_pkg::atan_turn(i);
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + e2q_pkg::atan_turn(i);
      end
    end
  end

  assign cos_q30 = xs[CORDIC_STAGES];
  assign sin_q30 = ys[CORDIC_STAGES];
endmodule

@@ hdl/e2q_quat.sv @@
module e2q_quat #(
  parameter int QUAT_FRAC_BITS = e2q_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic signed [e2q_pkg::CW-1:0] c0, s0, c1, s1, c2, s2,
  output logic signed [QUAT_FRAC_BITS:0] qw, qx, qy, qz
);
  localparam int CW = e2q_pkg::CW;
  localparam int WF = e2q_pkg::WORK_FRAC;
  localparam int SW = CW + 3;
  localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< QUAT_FRAC_BITS) - 1);
  localparam logic signed [SW-1:0] LO = -SW'(64'sd1 <<< QUAT_FRAC_BITS);

  // stage 1: pair products cc, cs, sc, ss of roll and pitch
  logic signed [CW-1:0] p_cc, p_cs, p_sc, p_ss, c2_r, s2_r;
  always_ff @(posedge clk) begin
    p_cc <= CW'((2*CW)'(c0 * c1) >>> WF);
    p_cs <= CW'((2*CW)'(c0 * s1) >>> WF);
    p_sc <= CW'((2*CW)'(s0 * c1) >>> WF);
    p_ss <= CW'((2*CW)'(s0 * s1) >>> WF);
    c2_r <= c2;
    s2_r <= s2;
  end

  // stage 2: multiply by yaw terms
  logic signed [CW-1:0] t [8];
  always_ff @(posedge clk) begin
    t[0] <= CW'((2*CW)'(p_cc * c2_r) >>> WF);
    t[1] <= CW'((2*CW)'(p_ss * s2_r) >>> WF);
    t[2] <= CW'((2*CW)'(p_sc * c2_r) >>> WF);
    t[3] <= CW'((2*CW)'(p_cs * s2_r) >>> WF);
    t[4] <= CW'((2*CW)'(p_cs * c2_r) >>> WF);
    t[5] <= CW'((2*CW)'(p_sc * s2_r) >>> WF);
    t[6] <= CW'((2*CW)'(p_cc * s2_r) >>> WF);
    t[7] <= CW'((2*CW)'(p_ss * c2_r) >>> WF);
  end

  // stage 3: sums
  logic signed [SW-1:0] sm [4];
  always_ff @(posedge clk) begin
    sm[0] <= SW'(t[0]) + SW'(t[1]);
    sm[1] <= SW'(t[2]) - SW'(t[3]);
    sm[2] <= SW'(t[4]) + SW'(t[5]);
    sm[3] <= SW'(t[6]) - SW'(t[7]);
  end

  function automatic logic signed [QUAT_FRAC_BITS:0] to_q(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    if (QUAT_FRAC_BITS < WF)
      r = (v + SW'(64'sd1 <<< (WF - QUAT_FRAC_BITS - 1))) >>> (WF - QUAT_FRAC_BITS);
    else
      r = v <<< (QUAT_FRAC_BITS - WF);
    if (r > HI) r = HI;
    if (r < LO) r = LO;
    return r[QUAT_FRAC_BITS:0];
  endfunction

  // stage 4: round and saturate
  always_ff @(posedge clk) begin
    qw <= to_q(sm[0]);
    qx <= to_q(sm[1]);
    qy <= to_q(sm[2]);
    qz <= to_q(sm[3]);
  end
endmodule
